### rtl/sfbc_pkg.sv
// ============================================================================
// sfbc_pkg: shared types and constants of the frame builder and checker
// Operation, kind and verdict codes, register indexes, controller states,
// and the command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package sfbc_pkg;

    // Operation carried in the input tuser.
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_RECEIVE = 2'd2;

    // Result kind carried in the output tuser.
    localparam logic [1:0] KIND_WIRE    = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;
    localparam logic [1:0] KIND_VERDICT = 2'd3;

    // Verdict codes.
    localparam logic [1:0] VERD_OK       = 2'd0;
    localparam logic [1:0] VERD_RESEND   = 2'd1;
    localparam logic [1:0] VERD_FAILED   = 2'd2;
    localparam logic [1:0] VERD_TOO_LONG = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W             = 1;
    localparam logic [0:0] CFG_CHECKSUM_CONSTANT = 1'd0;
    localparam logic [0:0] CFG_MAX_ATTEMPTS      = 1'd1;

    // Frame geometry.
    localparam int         RESULT_LIMIT = 64;
    localparam logic [6:0] HEADER_LEN   = 7'd3;
    localparam logic [6:0] FRAME_EXTRA  = 7'd4;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_HDR1,
        ST_HDR2,
        ST_CHECK,
        ST_PAD,
        ST_END,
        ST_RS_RD,
        ST_RS_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_RECEIVE
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_TOO_LONG,
        ACT_START,
        ACT_HDR1,
        ACT_HDR2,
        ACT_PAYLOAD,
        ACT_RECV,
        ACT_CHECK,
        ACT_PAD,
        ACT_VERDICT_OK,
        ACT_VERDICT_FAIL,
        ACT_RESEND_INIT,
        ACT_RESEND_READ,
        ACT_RESEND_OUT
    } act_t;

    typedef struct packed {
        act_t act;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic too_long;
        logic pay_done;
        logic send_zero;
        logic pos_end;
        logic rx_emit;
        logic sum_ok;
        logic att_out;
    } status_t;

endpackage

`default_nettype wire

### rtl/sfbc_ram.sv
// ============================================================================
// sfbc_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data until the next read.
// ============================================================================
`default_nettype none

module sfbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/sfbc_ctrl.sv
// ============================================================================
// sfbc_ctrl: frame sequencing controller
// Decides per cycle which datapath action runs and tracks the frame phase.
// ============================================================================
`default_nettype none

module sfbc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        op,
    input  wire logic              m_tready,
    input  wire sfbc_pkg::status_t status,
    output sfbc_pkg::cmd_t         cmd
);

    import sfbc_pkg::*;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.act    = ACT_NONE;
        cmd.last   = 1'b0;
        s_tready   = 1'b0;
        // The output register can take a result this cycle.
        load_ok    = !status.out_valid || m_tready;

        case (state_reg)
            ST_WAIT:
            begin
                s_tready = load_ok;
                if (s_tvalid && load_ok)
                begin
                    if (op == OP_START)
                    begin
                        if (status.too_long)
                        begin
                            cmd.act    = ACT_TOO_LONG;
                            cmd.last   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cmd.act    = ACT_START;
                            phase_next = PH_PAYLOAD;
                            state_next = ST_HDR1;
                        end
                    end
                    else if (op == OP_PAYLOAD && phase_reg == PH_PAYLOAD)
                    begin
                        cmd.act  = ACT_PAYLOAD;
                        cmd.last = !status.pay_done;
                        if (status.pay_done)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    else if (op == OP_RECEIVE && phase_reg == PH_RECEIVE)
                    begin
                        cmd.act  = ACT_RECV;
                        cmd.last = !status.pos_end;
                        if (status.pos_end)
                        begin
                            state_next = ST_END;
                        end
                    end
                end
            end

            ST_HDR1:
            begin
                if (load_ok)
                begin
                    cmd.act    = ACT_HDR1;
                    state_next = ST_HDR2;
                end
            end

            ST_HDR2:
            begin
                if (load_ok)
                begin
                    cmd.act    = ACT_HDR2;
                    cmd.last   = !status.send_zero;
                    state_next = status.send_zero ? ST_CHECK : ST_WAIT;
                end
            end

            ST_CHECK, ST_PAD:
            begin
                if (load_ok)
                begin
                    cmd.act  = (state_reg == ST_CHECK) ? ACT_CHECK : ACT_PAD;
                    cmd.last = status.pos_end;
                    if (status.pos_end)
                    begin
                        phase_next = PH_RECEIVE;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_END:
            begin
                if (load_ok)
                begin
                    if (status.sum_ok || status.att_out)
                    begin
                        cmd.act    = status.sum_ok ? ACT_VERDICT_OK : ACT_VERDICT_FAIL;
                        cmd.last   = 1'b1;
                        phase_next = PH_IDLE;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        cmd.act    = ACT_RESEND_INIT;
                        state_next = ST_RS_RD;
                    end
                end
            end

            ST_RS_RD:
            begin
                cmd.act    = ACT_RESEND_READ;
                state_next = ST_RS_OUT;
            end

            ST_RS_OUT:
            begin
                if (load_ok)
                begin
                    cmd.act    = ACT_RESEND_OUT;
                    cmd.last   = status.pos_end;
                    state_next = status.pos_end ? ST_WAIT : ST_RS_RD;
                end
            end

            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sfbc_datapath.sv
// ============================================================================
// sfbc_datapath: frame registers, sums, frame store and output register
// Carries out the controller's actions and reports the comparisons it needs.
// ============================================================================
`default_nettype none

module sfbc_datapath #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic [7:0]                    target_address,
    input  wire logic [7:0]                    command_code,
    input  wire logic [5:0]                    send_length,
    input  wire logic [5:0]                    receive_length,
    input  wire logic [7:0]                    data_byte,
    input  wire sfbc_pkg::cmd_t                cmd,
    input  wire logic                          m_tready,
    output sfbc_pkg::status_t                  status,
    output logic                               out_valid,
    output logic [1:0]                         out_kind,
    output logic [7:0]                         out_value,
    output logic [1:0]                         out_verdict,
    output logic                               out_last
);

    import sfbc_pkg::*;

    localparam int STORE_DEPTH = (MAX_FRAME < RESULT_LIMIT) ? MAX_FRAME : RESULT_LIMIT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam logic [6:0] FRAME_LIMIT = 7'(STORE_DEPTH);

    // Configuration registers.
    logic [7:0] const_reg;
    logic [2:0] max_att_reg;

    // Frame state.
    logic [6:0] pos_reg, pos_next;
    logic [6:0] fl_reg, fl_next;
    logic [5:0] sc_reg, sc_next;
    logic [5:0] rc_reg, rc_next;
    logic [7:0] psum_reg, psum_next;
    logic [7:0] rsum_reg, rsum_next;
    logic [2:0] att_reg, att_next;
    logic [7:0] cmd_byte_reg, cmd_byte_next;
    logic [7:0] hchk_reg, hchk_next;

    // Output register.
    logic       out_valid_reg;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [7:0] out_value_reg, out_value_next;
    logic [1:0] out_verdict_reg, out_verdict_next;
    logic       out_last_reg;
    logic       emit;

    // Frame store ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [7:0]    rd_data;

    logic [6:0] r_plus;
    logic [6:0] data_len;
    logic [6:0] fl_in;
    logic [6:0] pos_inc;

    assign r_plus   = {1'b0, receive_length} + 7'd1;
    assign data_len = ({1'b0, send_length} > r_plus) ? {1'b0, send_length} : r_plus;
    assign fl_in    = data_len + FRAME_EXTRA;
    assign pos_inc  = pos_reg + 7'd1;

    always_comb
    begin
        status.out_valid = out_valid_reg;
        status.too_long  = fl_in > FRAME_LIMIT;
        status.pay_done  = sc_reg == 6'd1;
        status.send_zero = sc_reg == 6'd0;
        status.pos_end   = pos_inc >= fl_reg;
        status.rx_emit   = (pos_reg >= HEADER_LEN) && (pos_reg <= HEADER_LEN + {1'b0, rc_reg});
        status.sum_ok    = rsum_reg == const_reg;
        status.att_out   = att_reg >= max_att_reg;
    end

    always_comb
    begin
        pos_next         = pos_reg;
        fl_next          = fl_reg;
        sc_next          = sc_reg;
        rc_next          = rc_reg;
        psum_next        = psum_reg;
        rsum_next        = rsum_reg;
        att_next         = att_reg;
        cmd_byte_next    = cmd_byte_reg;
        hchk_next        = hchk_reg;
        out_kind_next    = KIND_WIRE;
        out_value_next   = 8'd0;
        out_verdict_next = VERD_OK;
        emit             = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = pos_reg[AW-1:0];
        wr_data          = 8'd0;
        rd_en            = 1'b0;

        case (cmd.act)
            ACT_TOO_LONG:
            begin
                emit             = 1'b1;
                out_kind_next    = KIND_VERDICT;
                out_verdict_next = VERD_TOO_LONG;
            end

            ACT_START:
            begin
                fl_next       = fl_in;
                sc_next       = send_length;
                rc_next       = receive_length;
                psum_next     = 8'd0;
                rsum_next     = 8'd0;
                att_next      = 3'd1;
                cmd_byte_next = command_code;
                hchk_next     = const_reg - target_address - command_code;
                pos_next      = 7'd1;
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data       = ~target_address;
                emit          = 1'b1;
            end

            ACT_HDR1, ACT_HDR2, ACT_PAYLOAD, ACT_CHECK, ACT_PAD:
            begin
                wr_en    = 1'b1;
                emit     = 1'b1;
                pos_next = pos_inc;
                case (cmd.act)
                    ACT_HDR1:    wr_data = ~cmd_byte_reg;
                    ACT_HDR2:    wr_data = ~hchk_reg;
                    ACT_PAYLOAD: wr_data = ~data_byte;
                    ACT_CHECK:   wr_data = ~(const_reg - psum_reg);
                    default:     wr_data = 8'hFF;
                endcase
                if (cmd.act == ACT_PAYLOAD)
                begin
                    psum_next = psum_reg + data_byte;
                    sc_next   = sc_reg - 6'd1;
                end
                // The last check or padding byte hands the frame over to receiving.
                if ((cmd.act == ACT_CHECK || cmd.act == ACT_PAD) && status.pos_end)
                begin
                    pos_next  = 7'd0;
                    rsum_next = 8'd0;
                end
            end

            ACT_RECV:
            begin
                emit           = status.rx_emit;
                out_kind_next  = (pos_reg == HEADER_LEN) ? KIND_STATUS : KIND_DATA;
                out_value_next = data_byte;
                if (pos_reg >= HEADER_LEN)
                begin
                    rsum_next = rsum_reg + data_byte;
                end
                pos_next = pos_inc;
            end

            ACT_VERDICT_OK, ACT_VERDICT_FAIL:
            begin
                emit             = 1'b1;
                out_kind_next    = KIND_VERDICT;
                out_verdict_next = (cmd.act == ACT_VERDICT_OK) ? VERD_OK : VERD_FAILED;
            end

            ACT_RESEND_INIT:
            begin
                att_next  = att_reg + 3'd1;
                pos_next  = 7'd0;
                rsum_next = 8'd0;
            end

            ACT_RESEND_READ:
            begin
                rd_en = 1'b1;
            end

            ACT_RESEND_OUT:
            begin
                emit             = 1'b1;
                out_value_next   = rd_data;
                out_verdict_next = VERD_RESEND;
                pos_next         = status.pos_end ? 7'd0 : pos_inc;
            end

            default:
            begin
            end
        endcase

        // Sent bytes go out as stored, already inverted.
        if (wr_en)
        begin
            out_value_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_reg     <= 8'd0;
            max_att_reg   <= 3'd3;
            pos_reg       <= 7'd0;
            fl_reg        <= 7'd0;
            sc_reg        <= 6'd0;
            rc_reg        <= 6'd0;
            psum_reg      <= 8'd0;
            rsum_reg      <= 8'd0;
            att_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHECKSUM_CONSTANT: const_reg   <= cfg_data;
                    CFG_MAX_ATTEMPTS:      max_att_reg <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end
            pos_reg  <= pos_next;
            fl_reg   <= fl_next;
            sc_reg   <= sc_next;
            rc_reg   <= rc_next;
            psum_reg <= psum_next;
            rsum_reg <= rsum_next;
            att_reg  <= att_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_byte_reg <= cmd_byte_next;
        hchk_reg     <= hchk_next;
        if (emit)
        begin
            out_kind_reg    <= out_kind_next;
            out_value_reg   <= out_value_next;
            out_verdict_reg <= out_verdict_next;
            out_last_reg    <= cmd.last;
        end
    end

    sfbc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (pos_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_value   = out_value_reg;
    assign out_verdict = out_verdict_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

### rtl/spi_frame_build_check.sv
// ============================================================================
// spi_frame_build_check: bus frame builder and response checker
// Builds a header, payload, check byte and padding for each frame, keeps the
// sent frame, checks the response sum and re-sends on a bad sum up to the limit.
// ============================================================================
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  op in tuser, frame fields in tdata
//  m_*       out        m_tvalid / m_tready  kind in tuser, value and verdict
//                                            in tdata, end of run in tlast
//  cfg_*     in         cfg_we               checksum constant, attempt limit
//
// An item is accepted when the output register can take a result. A start item
// holds the block through the header states ST_HDR1 and ST_HDR2, and it or a
// closing payload byte through ST_CHECK and ST_PAD for the check and padding.
// A closing reply byte holds it through ST_END, and on a re-send through
// ST_RS_RD and ST_RS_OUT per stored byte, for the store's registered read.
// Reset clears the controller, counters and sums and sets the configuration
// to its defaults at once; the frame store needs no clearing pass because each
// byte read back was written earlier in the same frame.
// A stalled output holds the block: no new item is accepted while a waiting
// result cannot be replaced.
//
`default_nettype none

module spi_frame_build_check #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input items.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata, from bit 0: target_address[7:0], command_code[7:0],
    // send_length[5:0], receive_length[5:0], data_byte[7:0], zero fill.
    input  wire logic [39:0]                    s_tdata,
    // tuser: op[1:0].
    input  wire logic [1:0]                     s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata, from bit 0: value[7:0], verdict[1:0], zero fill.
    output logic [15:0]                         m_tdata,
    // tuser: kind[1:0].
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast,
    // Configuration writes.
    input  wire logic                           cfg_we,
    input  wire logic [sfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    import sfbc_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic [7:0] out_value;
    logic [1:0] out_verdict;

    // The controller decides when to accept an item and what each cycle does.
    sfbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the frame, the sums and the output register.
    sfbc_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .target_address (s_tdata[7:0]),
        .command_code   (s_tdata[15:8]),
        .send_length    (s_tdata[21:16]),
        .receive_length (s_tdata[27:22]),
        .data_byte      (s_tdata[35:28]),
        .cmd            (cmd),
        .m_tready       (m_tready),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_kind       (m_tuser),
        .out_value      (out_value),
        .out_verdict    (out_verdict),
        .out_last       (m_tlast)
    );

    assign m_tdata = {6'd0, out_verdict, out_value};

    // An item is taken only when the output register can accept a result.
    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input accepted while a result was stalled");

    // A verdict always closes the run of its item.
    a_verdict_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> m_tlast)
        else $error("verdict result not marked last");

    // The resend mark appears only on wire bytes.
    a_resend_on_wire: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[9:8] == VERD_RESEND) |-> (m_tuser == KIND_WIRE))
        else $error("resend mark on a result that is not a wire byte");

endmodule

`default_nettype wire
